FILE: rtl/ordered_list_table_macros.svh
// ----------------------------------------------------------------------------
// ordered list table assertion macros
// shared property forms for the list table checks
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_TABLE_MACROS_SVH
`define ORDERED_LIST_TABLE_MACROS_SVH

// same-cycle implication
`define OLT_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication
`define OLT_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

FILE: rtl/olt_pkg.sv
// ----------------------------------------------------------------------------
// olt_pkg
// types and codes shared by the ordered list table and its cells
// ----------------------------------------------------------------------------
package olt_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned LIST_IDX_W = 10;

   typedef enum logic [3:0] {
      FN_PUSH_BACK  = 4'd0,
      FN_POP_BACK   = 4'd1,
      FN_PUSH_FRONT = 4'd2,
      FN_POP_FRONT  = 4'd3,
      FN_INSERT     = 4'd4,
      FN_ERASE      = 4'd5,
      FN_FIND       = 4'd6,
      FN_REMOVE_ALL = 4'd7,
      FN_MODIFY     = 4'd8,
      FN_READ       = 4'd9,
      FN_CLEAR      = 4'd10
   } func_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_FULL     = 3'd1,
      STS_EMPTY    = 3'd2,
      STS_BADPOS   = 3'd3,
      STS_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      CM_HOLD   = 3'd0,
      CM_WRITE  = 3'd1,
      CM_OPEN   = 3'd2,
      CM_CLOSE  = 3'd3,
      CM_ROTATE = 3'd4
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type           mode;
      logic [LIST_IDX_W-1:0]   idx;
   } cell_cmd_type;

endpackage

FILE: rtl/ordered_list_table.sv
// ----------------------------------------------------------------------------
// ordered_list_table
// fixed-capacity ordered list of signed words held in a chain of cells
// ----------------------------------------------------------------------------
// Push, pop, insert, erase, modify and clear act on all cells at once and
// finish in the cycle the request beat is taken. Find, remove all and read
// rotate the list once through cell 0, one word per cycle, and answer when
// every stored element has passed through the head cell. One request is in
// work at a time, and the response sits in an output register; a new
// request is taken only in a cycle where that register is empty or its beat
// is leaving, so a stalled receiver holds off the request side.
module ordered_list_table
   import olt_pkg::*;
#(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // value[31:0], position[38:32], zero pad
   input  logic [3:0]  req_tuser,  // func[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // found_index[5:0], read_value[37:6], count[44:38], pad
   output logic [2:0]  rsp_tuser   // status[2:0]
);

   `include "ordered_list_table_macros.svh"

   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned IW   = $clog2(CAPACITY);
   localparam int unsigned CMPW = ((CW > 7) ? CW : 7) + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // request fields
   func_type          req_func;
   logic [WORD_W-1:0] req_value;
   logic [6:0]        req_position;

   assign req_func     = func_type'(req_tuser);
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[38:32];

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   func_type          op_ff, op_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic [6:0]        pos_ff, pos_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     total_ff, total_in;
   logic              hit_ff, hit_in;
   logic [IW-1:0]     fidx_ff, fidx_in;
   logic [WORD_W-1:0] rval_ff, rval_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [5:0]        rsp_found_ff, rsp_found_in;
   logic [WORD_W-1:0] rsp_read_ff, rsp_read_in;
   logic [6:0]        rsp_count_ff, rsp_count_in;

   cell_cmd_type      cmd;
   logic [WORD_W-1:0] cell_word [CAPACITY];
   logic [WORD_W-1:0] head;
   logic              req_fire;
   logic              head_match;
   logic              last_step;
   logic [CMPW-1:0]   pos_x;
   logic [CMPW-1:0]   cnt_x;
   logic              is_full;
   logic              is_empty;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign head       = cell_word[0];
   assign head_match = (head == value_ff);
   assign last_step  = (step_ff == (total_ff - CW'(1)));
   assign pos_x      = CMPW'(req_position);
   assign cnt_x      = CMPW'(count_ff);
   assign is_full    = (count_ff == CW'(CAPACITY));
   assign is_empty   = (count_ff == '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      len_in        = len_ff;
      total_in      = total_ff;
      hit_in        = hit_ff;
      fidx_in       = fidx_ff;
      rval_in       = rval_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_count_in  = rsp_count_ff;
      cmd           = '{mode: CM_HOLD, idx: '0};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               logic             scan;
               status_type       sts;
               scan     = 1'b0;
               sts      = STS_OK;
               op_in    = req_func;
               value_in = req_value;
               pos_in   = req_position;
               step_in  = '0;
               len_in   = count_ff;
               total_in = count_ff;
               hit_in   = 1'b0;
               fidx_in  = '0;
               rval_in  = '0;
               unique case (req_func)
                  FN_PUSH_BACK: begin
                     if (is_full) sts = STS_FULL;
                     else begin
                        cmd      = '{mode: CM_WRITE, idx: LIST_IDX_W'(count_ff)};
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FN_POP_BACK: begin
                     if (is_empty) sts = STS_EMPTY;
                     else count_in = count_ff - CW'(1);
                  end
                  FN_PUSH_FRONT: begin
                     if (is_full) sts = STS_FULL;
                     else begin
                        cmd      = '{mode: CM_OPEN, idx: '0};
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FN_POP_FRONT: begin
                     if (is_empty) sts = STS_EMPTY;
                     else begin
                        cmd      = '{mode: CM_CLOSE, idx: '0};
                        count_in = count_ff - CW'(1);
                     end
                  end
                  FN_INSERT: begin
                     if (is_full) sts = STS_FULL;
                     else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) sts = STS_BADPOS;
                     else begin
                        cmd      = '{mode: CM_OPEN, idx: LIST_IDX_W'(pos_x - CMPW'(1))};
                        count_in = count_ff + CW'(1);
                     end
                  end
                  FN_ERASE: begin
                     if (is_empty) sts = STS_EMPTY;
                     else if (pos_x == '0 || pos_x > cnt_x) sts = STS_BADPOS;
                     else begin
                        cmd      = '{mode: CM_CLOSE, idx: LIST_IDX_W'(pos_x - CMPW'(1))};
                        count_in = count_ff - CW'(1);
                     end
                  end
                  FN_FIND: begin
                     if (is_empty) sts = STS_NOTFOUND;
                     else scan = 1'b1;
                  end
                  FN_REMOVE_ALL: begin
                     if (!is_empty) scan = 1'b1;
                  end
                  FN_MODIFY: begin
                     if (pos_x == '0 || pos_x > cnt_x) sts = STS_BADPOS;
                     else cmd = '{mode: CM_WRITE, idx: LIST_IDX_W'(pos_x - CMPW'(1))};
                  end
                  FN_READ: begin
                     if (pos_x >= cnt_x) sts = STS_BADPOS;
                     else scan = 1'b1;
                  end
                  FN_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     sts = STS_OK;
                  end
               endcase
               if (scan) begin
                  state_in = ST_SCAN;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = sts;
                  rsp_found_in  = '0;
                  rsp_read_in   = '0;
                  rsp_count_in  = 7'(count_in);
               end
            end
         end
         ST_SCAN: begin
            logic [CW-1:0]     len_next;
            logic              hit_now;
            logic [IW-1:0]     fidx_now;
            logic [WORD_W-1:0] rval_now;
            len_next = len_ff;
            if (op_ff == FN_REMOVE_ALL && head_match) begin
               cmd      = '{mode: CM_CLOSE, idx: '0};
               len_next = len_ff - CW'(1);
            end else begin
               cmd = '{mode: CM_ROTATE, idx: LIST_IDX_W'(len_ff - CW'(1))};
            end
            hit_now  = hit_ff || head_match;
            fidx_now = hit_ff ? fidx_ff : IW'(step_ff);
            rval_now = (CMPW'(step_ff) == CMPW'(pos_ff)) ? head : rval_ff;
            len_in   = len_next;
            hit_in   = hit_now;
            fidx_in  = fidx_now;
            rval_in  = rval_now;
            step_in  = step_ff + CW'(1);
            if (last_step) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = STS_OK;
               rsp_found_in  = '0;
               rsp_read_in   = '0;
               rsp_count_in  = 7'(count_ff);
               priority if (op_ff == FN_REMOVE_ALL) begin
                  count_in     = len_next;
                  rsp_count_in = 7'(len_next);
               end else if (op_ff == FN_FIND) begin
                  rsp_status_in = hit_now ? STS_OK : STS_NOTFOUND;
                  rsp_found_in  = hit_now ? 6'(fidx_now) : '0;
               end else begin
                  rsp_read_in = rval_now;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = req_value;
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end
      olt_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_word  (left_word),
         .right_word (right_word),
         .head_word  (head),
         .value      (req_value),
         .word       (cell_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      len_ff        <= len_in;
      total_ff      <= total_in;
      hit_ff        <= hit_in;
      fidx_ff       <= fidx_in;
      rval_ff       <= rval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_read_ff, rsp_found_ff};

   `OLT_ASSERT_IMPLY(a_scan_no_rsp, clock, reset, state_ff == ST_SCAN, !rsp_valid_ff, "response pending during scan")
   `OLT_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY), "count above capacity")
   `OLT_ASSERT_IMPLY(a_scan_len, clock, reset, state_ff == ST_SCAN, len_ff <= total_ff && step_ff < total_ff, "scan length out of range")
   `OLT_ASSERT_NEXT(a_scan_count, clock, reset, state_ff == ST_SCAN && op_ff != FN_REMOVE_ALL, count_ff == $past(count_ff), "count moved during scan")

endmodule

FILE: rtl/olt_cell.sv
// ----------------------------------------------------------------------------
// olt_cell
// one word of the list; takes its left or right neighbor, the head word
// or the request value as the broadcast command selects
// ----------------------------------------------------------------------------
module olt_cell
   import olt_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic              clock,
   input  cell_cmd_type      cmd,
   input  logic [WORD_W-1:0] left_word,
   input  logic [WORD_W-1:0] right_word,
   input  logic [WORD_W-1:0] head_word,
   input  logic [WORD_W-1:0] value,
   output logic [WORD_W-1:0] word
);

   localparam logic [LIST_IDX_W-1:0] MY_IDX = LIST_IDX_W'(INDEX);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (cmd.mode)
         CM_HOLD: begin
            word_in = word_ff;
         end
         CM_WRITE: begin
            if (cmd.idx == MY_IDX) word_in = value;
         end
         CM_OPEN: begin
            if (MY_IDX > cmd.idx) word_in = left_word;
            else if (MY_IDX == cmd.idx) word_in = value;
         end
         CM_CLOSE: begin
            if (MY_IDX >= cmd.idx) word_in = right_word;
         end
         CM_ROTATE: begin
            if (MY_IDX < cmd.idx) word_in = right_word;
            else if (MY_IDX == cmd.idx) word_in = head_word;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule
